// ----- sv/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants and controller/datapath interface types for the source
// component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int NODE_DEF = 1024;
  localparam int EDGE_DEF = 4096;
  localparam int IO_W     = 11;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic edge_drop;
    logic edge_rd;
    logic edge_wr;
    logic cmp_start;
    logic p1_rd;
    logic p1_root;
    logic p1_next;
    logic p2_init;
    logic p2_rd;
    logic p2_look;
    logic p2_root;
    logic p2_next;
    logic step_edge;
    logic step_fin;
    logic pop_ld;
    logic edge_take;
    logic push;
    logic res_ld;
    logic pass2;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_bad;
    logic p1_end;
    logic p1_unseen;
    logic p2_end;
    logic p2_ok;
    logic p2_unseen;
    logic cur_end;
    logic last_pop;
    logic v_ok;
    logic push_ok;
    logic out_full;
  } sts_t;

endpackage

// ----- sv/scc_dpath.sv -----
// ----------------------------------------------------------------------------
// scc_dpath
// Edge store, visited maps, finish order, walk stack, counters and the
// result register of the source component counter.
// ----------------------------------------------------------------------------
module scc_dpath #(
  parameter int MAX_NODES = scc_pkg::NODE_DEF,
  parameter int MAX_EDGES = scc_pkg::EDGE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  scc_pkg::cmd_t             cmd,
  output scc_pkg::sts_t             sts,
  input  logic                      cfg_valid,
  input  logic [scc_pkg::IO_W-1:0]  cfg_node_count,
  input  logic [scc_pkg::IO_W-1:0]  in_src_node,
  input  logic [scc_pkg::IO_W-1:0]  in_dst_node,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [scc_pkg::IO_W-1:0]  out_start_count,
  output logic                      out_overflow
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int DW  = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW  = (DW > scc_pkg::IO_W) ? DW : scc_pkg::IO_W;
  localparam int SW  = NW + EW;
  localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGES);

  logic [scc_pkg::IO_W-1:0] node_count_r;
  logic [CW-1:0]            n_eff;
  logic [CW-1:0]            src_ext;
  logic [CW-1:0]            dst_ext;
  logic [CW-1:0]            src_m1;
  logic [CW-1:0]            dst_m1;
  logic [CW-1:0]            cnt_ext;

  logic [EW-1:0] et_r;
  logic          drop_r;
  logic [NW-1:0] s_r;
  logic [NW-1:0] d_r;
  logic [DW-1:0] i_r;
  logic [DW-1:0] ftot_r;
  logic [DW-1:0] cnt_r;
  logic [DW-1:0] depth_r;
  logic [NW-1:0] top_node_r;
  logic [EW-1:0] top_cur_r;
  logic [NW-1:0] v_r;
  logic [NW-1:0] f_r;
  logic [NW-1:0] clr_cnt_r;
  logic          out_valid_r;
  logic [scc_pkg::IO_W-1:0] out_count_r;
  logic          out_ovf_r;

  logic [EW-1:0] head_mem  [MAX_NODES];
  logic [NW-1:0] tgt_mem   [MAX_EDGES];
  logic [EW-1:0] lnk_mem   [MAX_EDGES];
  logic          seen1_mem [MAX_NODES];
  logic          seen2_mem [MAX_NODES];
  logic [NW-1:0] fo_mem    [MAX_NODES];
  logic [SW-1:0] stk_mem   [MAX_NODES];

  logic [EW-1:0] head_rd_r;
  logic [NW-1:0] tgt_rd_r;
  logic [EW-1:0] lnk_rd_r;
  logic          seen1_rd_r;
  logic          seen2_rd_r;
  logic [NW-1:0] fo_rd_r;
  logic [SW-1:0] stk_rd_r;

  logic [NW-1:0] head_ra;
  logic [NW-1:0] seen_ra;
  logic [DW-1:0] fo_ra_full;
  logic [DW-1:0] stk_wa_full;
  logic [DW-1:0] stk_ra_full;
  logic          seen1_we;
  logic          seen2_we;
  logic [NW-1:0] seen_wa;
  logic          seen_wd;
  logic          fo_we;

  assign n_eff   = (CW'(node_count_r) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_r);
  assign src_ext = CW'(in_src_node);
  assign dst_ext = CW'(in_dst_node);
  assign src_m1  = src_ext - CW'(1);
  assign dst_m1  = dst_ext - CW'(1);
  assign cnt_ext = CW'(cnt_r);

  always_comb begin
    if (cmd.edge_rd) begin
      head_ra = src_m1[NW-1:0];
    end else if (cmd.p1_rd) begin
      head_ra = i_r[NW-1:0];
    end else if (cmd.edge_take) begin
      head_ra = tgt_rd_r;
    end else begin
      head_ra = fo_rd_r;
    end
    if (cmd.p1_rd) begin
      seen_ra = i_r[NW-1:0];
    end else if (cmd.edge_take) begin
      seen_ra = tgt_rd_r;
    end else begin
      seen_ra = fo_rd_r;
    end
    seen1_we = cmd.clr_step || cmd.p1_root || (cmd.push && !cmd.pass2);
    seen2_we = cmd.clr_step || cmd.p2_root || (cmd.push && cmd.pass2);
    seen_wd  = !cmd.clr_step;
    if (cmd.clr_step) begin
      seen_wa = clr_cnt_r;
    end else if (cmd.p1_root) begin
      seen_wa = i_r[NW-1:0];
    end else if (cmd.p2_root) begin
      seen_wa = f_r;
    end else begin
      seen_wa = v_r;
    end
    fo_we       = cmd.step_fin && !cmd.pass2 && (ftot_r < DW'(MAX_NODES));
    fo_ra_full  = i_r - DW'(1);
    stk_wa_full = depth_r - DW'(1);
    stk_ra_full = depth_r - DW'(2);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      head_mem[clr_cnt_r] <= NO_EDGE;
    end else if (cmd.edge_wr) begin
      head_mem[s_r] <= et_r;
    end
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (seen1_we) begin
      seen1_mem[seen_wa] <= seen_wd;
    end
    seen1_rd_r <= seen1_mem[seen_ra];
  end

  always_ff @(posedge clk) begin
    if (seen2_we) begin
      seen2_mem[seen_wa] <= seen_wd;
    end
    seen2_rd_r <= seen2_mem[seen_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      tgt_mem[et_r[EAW-1:0]] <= d_r;
      lnk_mem[et_r[EAW-1:0]] <= head_rd_r;
    end
    tgt_rd_r <= tgt_mem[top_cur_r[EAW-1:0]];
    lnk_rd_r <= lnk_mem[top_cur_r[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fo_we) begin
      fo_mem[ftot_r[NW-1:0]] <= top_node_r;
    end
    fo_rd_r <= fo_mem[fo_ra_full[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[stk_wa_full[NW-1:0]] <= {top_node_r, top_cur_r};
    end
    stk_rd_r <= stk_mem[stk_ra_full[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_rd) begin
      s_r <= src_m1[NW-1:0];
      d_r <= dst_m1[NW-1:0];
    end
    if (cmd.cmp_start) begin
      i_r    <= '0;
      ftot_r <= '0;
      cnt_r  <= '0;
    end
    if (cmd.p1_next) begin
      i_r <= i_r + DW'(1);
    end
    if (cmd.p2_init) begin
      i_r <= ftot_r;
    end
    if (cmd.p2_next) begin
      i_r <= i_r - DW'(1);
    end
    if (cmd.p2_look) begin
      f_r <= fo_rd_r;
    end
    if (cmd.p1_root) begin
      top_node_r <= i_r[NW-1:0];
      top_cur_r  <= head_rd_r;
      depth_r    <= DW'(1);
    end
    if (cmd.p2_root) begin
      top_node_r <= f_r;
      top_cur_r  <= head_rd_r;
      depth_r    <= DW'(1);
      cnt_r      <= cnt_r + DW'(1);
    end
    if (cmd.step_fin) begin
      depth_r <= depth_r - DW'(1);
    end
    if (fo_we) begin
      ftot_r <= ftot_r + DW'(1);
    end
    if (cmd.pop_ld) begin
      {top_node_r, top_cur_r} <= stk_rd_r;
    end
    if (cmd.edge_take) begin
      top_cur_r <= lnk_rd_r;
      v_r       <= tgt_rd_r;
    end
    if (cmd.push) begin
      top_node_r <= v_r;
      top_cur_r  <= head_rd_r;
      depth_r    <= depth_r + DW'(1);
    end
    if (cmd.res_ld) begin
      out_count_r <= cnt_ext[scc_pkg::IO_W-1:0];
      out_ovf_r   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      et_r         <= '0;
      drop_r       <= 1'b0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_count_r <= cfg_node_count;
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + NW'(1);
      end
      if (cmd.edge_drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.edge_wr) begin
        et_r <= et_r + EW'(1);
      end
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
        drop_r      <= 1'b0;
        et_r        <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clr_last  = (clr_cnt_r == NW'(MAX_NODES - 1));
    sts.in_bad    = (src_ext == '0) || (dst_ext == '0) || (src_ext > n_eff) ||
                    (dst_ext > n_eff) || (et_r >= NO_EDGE);
    sts.p1_end    = (CW'(i_r) == n_eff);
    sts.p1_unseen = !seen1_rd_r;
    sts.p2_end    = (i_r == '0);
    sts.p2_ok     = (CW'(fo_rd_r) < n_eff);
    sts.p2_unseen = !seen2_rd_r;
    sts.cur_end   = (top_cur_r >= NO_EDGE);
    sts.last_pop  = (depth_r == DW'(1));
    sts.v_ok      = (CW'(tgt_rd_r) < n_eff);
    sts.push_ok   = !(cmd.pass2 ? seen2_rd_r : seen1_rd_r) && (depth_r < DW'(MAX_NODES));
    sts.out_full  = out_valid_r && out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_start_count = out_count_r;
  assign out_overflow    = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (depth_r < DW'(MAX_NODES)))
    else $error("push with a full walk stack");
  a_edge_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.edge_wr |-> (et_r < NO_EDGE))
    else $error("edge written past capacity");
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> !(out_valid_r && out_stall))
    else $error("result loaded over a waiting result");
  a_res_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> (et_r == '0) && !drop_r)
    else $error("edge store not emptied after result");
`endif

endmodule

// ----- sv/scc_ctrl.sv -----
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loading, both graph walks, result hand-off and the
// clearing sweep of the source component counter.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_stall,
  input  scc_pkg::sts_t sts,
  output scc_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ADD    = 13'b0000000000100,
    S_P1_RD  = 13'b0000000001000,
    S_P1_CHK = 13'b0000000010000,
    S_STEP   = 13'b0000000100000,
    S_POP    = 13'b0000001000000,
    S_EDGE   = 13'b0000010000000,
    S_CHECK  = 13'b0000100000000,
    S_P2_RD  = 13'b0001000000000,
    S_P2_F   = 13'b0010000000000,
    S_P2_CHK = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            cmd.cmp_start = 1'b1;
            pass2_nxt     = 1'b0;
            state_nxt     = S_P1_RD;
          end else if (sts.in_bad) begin
            cmd.edge_drop = 1'b1;
          end else begin
            cmd.edge_rd = 1'b1;
            state_nxt   = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.edge_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_P1_RD: begin
        if (sts.p1_end) begin
          cmd.p2_init = 1'b1;
          pass2_nxt   = 1'b1;
          state_nxt   = S_P2_RD;
        end else begin
          cmd.p1_rd = 1'b1;
          state_nxt = S_P1_CHK;
        end
      end
      S_P1_CHK: begin
        if (sts.p1_unseen) begin
          cmd.p1_root = 1'b1;
          state_nxt   = S_STEP;
        end else begin
          cmd.p1_next = 1'b1;
          state_nxt   = S_P1_RD;
        end
      end
      S_STEP: begin
        if (sts.cur_end) begin
          cmd.step_fin = 1'b1;
          if (!sts.last_pop) begin
            state_nxt = S_POP;
          end else if (pass2_r) begin
            cmd.p2_next = 1'b1;
            state_nxt   = S_P2_RD;
          end else begin
            cmd.p1_next = 1'b1;
            state_nxt   = S_P1_RD;
          end
        end else begin
          cmd.step_edge = 1'b1;
          state_nxt     = S_EDGE;
        end
      end
      S_POP: begin
        cmd.pop_ld = 1'b1;
        state_nxt  = S_STEP;
      end
      S_EDGE: begin
        cmd.edge_take = 1'b1;
        state_nxt     = sts.v_ok ? S_CHECK : S_STEP;
      end
      S_CHECK: begin
        cmd.push  = sts.push_ok;
        state_nxt = S_STEP;
      end
      S_P2_RD: begin
        if (sts.p2_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.p2_rd = 1'b1;
          state_nxt = S_P2_F;
        end
      end
      S_P2_F: begin
        if (sts.p2_ok) begin
          cmd.p2_look = 1'b1;
          state_nxt   = S_P2_CHK;
        end else begin
          cmd.p2_next = 1'b1;
          state_nxt   = S_P2_RD;
        end
      end
      S_P2_CHK: begin
        if (sts.p2_unseen) begin
          cmd.p2_root = 1'b1;
          state_nxt   = S_STEP;
        end else begin
          cmd.p2_next = 1'b1;
          state_nxt   = S_P2_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.res_ld    = 1'b1;
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLEAR;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    cmd.pass2 = pass2_r;
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_mode && !sts.in_bad) |=> (state_r == S_ADD))
    else $error("valid edge beat not followed by a store cycle");
  a_walk_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2_CHK) |-> pass2_r)
    else $error("second pass check outside the second pass");
  a_res_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> (state_r == S_CLEAR))
    else $error("result not followed by the clearing sweep");
`endif

endmodule

// ----- sv/source_component_count.sv -----
// ----------------------------------------------------------------------------
// source_component_count
// Counts the source components of a directed graph loaded one edge per beat.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_mode, in_src_node, in_dst_node
//   out      output     out_valid/out_stall out_start_count, out_overflow
//   cfg      input      cfg_valid/cfg_ready cfg_node_count
//
// An edge beat reads the list head, then writes the store; a dropped edge
// is only flagged. A compute beat runs two stack-based walks for N nodes and
// E edges: each node slot is looked at, each visited node is finished, each
// one below a walk root is popped, and each edge is followed. A hand-off and
// a clearing sweep of all MAX_NODES list heads and visited-map entries
// follow. After reset the same sweep runs before the first input beat is
// taken. A stalled result holds the finished walk until the result register
// is free; cfg_ready is always high.
// ----------------------------------------------------------------------------
module source_component_count #(
  parameter int MAX_NODES = scc_pkg::NODE_DEF,
  parameter int MAX_EDGES = scc_pkg::EDGE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic [scc_pkg::IO_W-1:0] in_src_node,
  input  logic [scc_pkg::IO_W-1:0] in_dst_node,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [scc_pkg::IO_W-1:0] out_start_count,
  output logic                     out_overflow,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [scc_pkg::IO_W-1:0] cfg_node_count
);

  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scc_dpath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_node_count  (cfg_node_count),
    .in_src_node     (in_src_node),
    .in_dst_node     (in_dst_node),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_start_count (out_start_count),
    .out_overflow    (out_overflow)
  );

endmodule

// ----- bench/source_component_count_test.sv -----
// ----------------------------------------------------------------------------
// source_component_count_test
// Self-checking bench for the source component counter. Edge and compute
// beats are queued per phase, driven in random bursts, and each result is
// compared with the count predicted by a two-pass depth-first search.
// ----------------------------------------------------------------------------
module source_component_count_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = scc_pkg::NODE_DEF;
  localparam int EDGES = scc_pkg::EDGE_DEF;
  localparam int W = scc_pkg::IO_W;
  localparam bit MODE_EDGE = 1'b0;
  localparam bit MODE_COUNT = 1'b1;
  localparam int SETTLE = 1200;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic mode;
    logic [W-1:0] src;
    logic [W-1:0] dst;
    bit drain;
  } beat_t;

  typedef struct {
    logic [W-1:0] count;
    logic ovf;
  } tally_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_mode = 0;
  logic [W-1:0] in_src_node = '0;
  logic [W-1:0] in_dst_node = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [W-1:0] out_start_count;
  logic out_overflow;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [W-1:0] cfg_node_count = '0;

  source_component_count dut (.*);

  initial forever #5 clk = ~clk;

  beat_t pending[$];
  tally_t tallies[$];
  beat_t cur;
  int errors = 0;
  int burst_left = 5;
  int gap_left = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  // Shadow of the graph store.
  int nodes_cfg = 0;
  int tgt[EDGES];
  int nxt[EDGES];
  int head[NODES];
  int edge_cnt = 0;
  bit dropped = 0;
  bit seen1[NODES];
  bit seen2[NODES];
  int order[NODES];
  int order_cnt;
  int stk_node[NODES];
  int stk_cur[NODES];

  function automatic void graph_clear();
    for (int i = 0; i < NODES; i++) head[i] = EDGES;
    edge_cnt = 0;
  endfunction

  function automatic void search(int root, int n, bit first);
    int depth;
    int top;
    int c;
    int v;
    if (first) seen1[root] = 1; else seen2[root] = 1;
    stk_node[0] = root;
    stk_cur[0] = head[root];
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      c = stk_cur[top];
      if (c >= EDGES) begin
        if (first && order_cnt < NODES) begin
          order[order_cnt] = stk_node[top];
          order_cnt++;
        end
        depth--;
      end else begin
        v = tgt[c];
        stk_cur[top] = nxt[c];
        if (v < n && !(first ? seen1[v] : seen2[v]) && depth < NODES) begin
          if (first) seen1[v] = 1; else seen2[v] = 1;
          stk_node[depth] = v;
          stk_cur[depth] = head[v];
          depth++;
        end
      end
    end
  endfunction

  function automatic void apply_beat(beat_t b);
    int n;
    int cnt;
    tally_t t;
    n = nodes_cfg > NODES ? NODES : nodes_cfg;
    if (b.mode == MODE_EDGE) begin
      if (b.src == 0 || b.dst == 0 || b.src > n || b.dst > n || edge_cnt >= EDGES) begin
        dropped = 1;
      end else begin
        tgt[edge_cnt] = b.dst - 1;
        nxt[edge_cnt] = head[b.src - 1];
        head[b.src - 1] = edge_cnt;
        edge_cnt++;
      end
    end else begin
      for (int i = 0; i < NODES; i++) begin
        seen1[i] = 0;
        seen2[i] = 0;
      end
      order_cnt = 0;
      for (int i = 0; i < n; i++) if (!seen1[i]) search(i, n, 1);
      cnt = 0;
      for (int i = order_cnt; i > 0; i--) begin
        if (order[i-1] < n && !seen2[order[i-1]]) begin
          search(order[i-1], n, 0);
          cnt++;
        end
      end
      t.count = cnt[W-1:0];
      t.ovf = dropped;
      tallies = {tallies, t};
      graph_clear();
      dropped = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) apply_beat(cur);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pending.size() > 0 && !(pending[0].drain && tallies.size() > 0)) begin
          cur = pending.pop_front();
          in_mode <= cur.mode;
          in_src_node <= cur.src;
          in_dst_node <= cur.dst;
          in_valid <= 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_req <= 0;
      hold_cnt <= 3000;
      out_stall <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 3) * 25;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    tally_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (tallies.size() == 0) begin
        $display("%0t: result with none expected: count %0d overflow %0d",
                 $time, out_start_count, out_overflow);
        errors++;
      end else begin
        t = tallies.pop_front();
        if (out_start_count !== t.count) begin
          $display("%0t: start_count expected %0d actual %0d", $time, t.count,
                   out_start_count);
          errors++;
        end
        if (out_overflow !== t.ovf) begin
          $display("%0t: overflow expected %0d actual %0d", $time, t.ovf, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_beat(logic mode, int s, int d, bit drain = 0);
    beat_t b;
    b.mode = mode;
    b.src = s[W-1:0];
    b.dst = d[W-1:0];
    b.drain = drain;
    pending = {pending, b};
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (pending.size() > 0 || in_valid || tallies.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_nodes(int v);
    wait_quiet();
    @(posedge clk);
    cfg_valid <= 1;
    cfg_node_count <= v[W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    nodes_cfg = v;
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic random_graph(int n, int edges, bit noisy);
    for (int i = 0; i < edges; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        push_beat(MODE_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        push_beat(MODE_EDGE, $urandom_range(1, n), $urandom_range(1, n));
    end
    push_beat(MODE_COUNT, $urandom_range(0, 2047), $urandom_range(0, 2047));
  endtask

  initial begin
    int sent;
    int n;
    int e;
    graph_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Empty graph, then a single node with a self loop and bad endpoints.
    set_nodes(0);
    push_beat(MODE_EDGE, 1, 1);
    push_beat(MODE_COUNT, 0, 0);
    set_nodes(1);
    push_beat(MODE_EDGE, 1, 1);
    push_beat(MODE_EDGE, 0, 1);
    push_beat(MODE_COUNT, 2047, 2047);
    push_beat(MODE_COUNT, 0, 0);
    // Node count above the maximum, extreme endpoints.
    set_nodes(2047);
    push_beat(MODE_EDGE, 1024, 1);
    push_beat(MODE_EDGE, 1, 1024);
    push_beat(MODE_EDGE, 1025, 3);
    push_beat(MODE_EDGE, 2047, 2047);
    push_beat(MODE_COUNT, 0, 0);
    set_nodes(1024);
    push_beat(MODE_EDGE, 512, 1024);
    push_beat(MODE_EDGE, 1024, 512);
    push_beat(MODE_COUNT, 0, 0);
    // Node count lowered after loading a cycle and a chain.
    set_nodes(10);
    push_beat(MODE_EDGE, 1, 2);
    push_beat(MODE_EDGE, 2, 10);
    push_beat(MODE_EDGE, 10, 1);
    push_beat(MODE_EDGE, 3, 4);
    set_nodes(5);
    push_beat(MODE_COUNT, 0, 0);

    // Long result hold-off with many computes queued behind it.
    set_nodes(6);
    hold_req = 1;
    for (int k = 0; k < 12; k++) random_graph(6, 3, 0);
    push_beat(MODE_EDGE, 2, 3, 1);
    push_beat(MODE_COUNT, 0, 0);

    // Store full.
    set_nodes(12);
    random_graph(12, EDGES + 4, 0);

    sent = 0;
    while (sent < 1200) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 24);
      set_nodes(n);
      if (n == 0) n = 1;
      if (n > NODES) n = NODES;
      for (int k = $urandom_range(1, 4); k > 0; k--) begin
        e = $urandom_range(0, 3 * (n > 24 ? 24 : n));
        random_graph(n, e, 1);
        sent += e + 1;
      end
    end

    wait_quiet();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
